// ----- rtl/pgs_pkg.sv -----
// Shared types and constants for the periodic grid stencil unit.
// Used by every module of the block but pgs_grid_mem; depends on nothing.
package pgs_pkg;

  localparam int unsigned SIDE_BITS_DEF = 4;
  localparam int unsigned INDEX_W       = 12;
  localparam int unsigned VALUE_W       = 24;
  localparam int unsigned LAP_W         = 32;
  localparam int unsigned GRAD_W        = 29;
  localparam int unsigned STEP_W        = 4;

  // Step 0 reads the center; steps 1 to 12 read the neighbors axis by axis.
  localparam logic [STEP_W-1:0] STEP_CENTER = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd12;

  localparam logic [1:0] AXIS_SLOW = 2'd0;
  localparam logic [1:0] AXIS_MID  = 2'd1;
  localparam logic [1:0] AXIS_FAST = 2'd2;

  localparam logic [1:0] NB_M2 = 2'd0;
  localparam logic [1:0] NB_M1 = 2'd1;
  localparam logic [1:0] NB_P1 = 2'd2;
  localparam logic [1:0] NB_P2 = 2'd3;

  localparam int signed CENTER_COEF = -90;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } pgs_state_e;

  typedef struct packed {
    logic              valid;
    logic [STEP_W-1:0] step;
  } pgs_tap_t;

endpackage

// ----- rtl/pgs_grid_mem.sv -----
// Single-port grid sample memory with registered read data.
// Depends on nothing but its parameters.
module pgs_grid_mem #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 24
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pgs_seq.sv -----
// Query sequencer: walks the thirteen stencil reads and tags the read data.
// Depends on pgs_pkg.
module pgs_seq #(
  parameter int unsigned SIDE_BITS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       query_i,
  input  logic [pgs_pkg::INDEX_W-1:0] index_i,
  output logic                       busy_o,
  output logic                       rd_en_o,
  output logic [3*SIDE_BITS-1:0]     rd_addr_o,
  output pgs_pkg::pgs_tap_t          tap_o
);
  import pgs_pkg::*;

  localparam int unsigned CELL_W = 3 * SIDE_BITS;

  pgs_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CELL_W-1:0] idx_q;
  pgs_tap_t          tap_q;

  logic [STEP_W-1:0]    step_m1;
  logic [1:0]           axis;
  logic [1:0]           nb;
  logic [SIDE_BITS-1:0] off;
  logic [SIDE_BITS-1:0] ps, pm, pf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_CENTER;
      tap_q   <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      tap_q.valid <= (state_q == ST_READ);
      tap_q.step  <= step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_i && state_q == ST_IDLE) begin
      idx_q <= CELL_W'(index_i);
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = STEP_CENTER;
        if (query_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    step_m1 = step_q - STEP_W'(1);
    axis    = step_m1[3:2];
    nb      = step_m1[1:0];
    unique case (nb)
      NB_M2:   off = '1 - SIDE_BITS'(1);
      NB_M1:   off = '1;
      NB_P1:   off = SIDE_BITS'(1);
      default: off = SIDE_BITS'(2);
    endcase
    ps = idx_q[CELL_W-1:2*SIDE_BITS];
    pm = idx_q[2*SIDE_BITS-1:SIDE_BITS];
    pf = idx_q[SIDE_BITS-1:0];
    if (step_q != STEP_CENTER) begin
      priority case (axis)
        AXIS_SLOW: ps = ps + off;
        AXIS_MID:  pm = pm + off;
        default:   pf = pf + off;
      endcase
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign rd_en_o   = (state_q == ST_READ);
  assign rd_addr_o = {ps, pm, pf};
  assign tap_o     = tap_q;

endmodule

// ----- rtl/pgs_accum.sv -----
// Shared accumulate unit: folds each tagged sample into the Laplacian and gradient sums.
// Depends on pgs_pkg.
module pgs_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pgs_pkg::pgs_tap_t                 tap_i,
  input  logic signed [pgs_pkg::VALUE_W-1:0] sample_i,
  output logic                              result_valid_o,
  output logic signed [pgs_pkg::LAP_W-1:0]  laplacian_sum_o,
  output logic signed [pgs_pkg::GRAD_W-1:0] grad_slow_o,
  output logic signed [pgs_pkg::GRAD_W-1:0] grad_mid_o,
  output logic signed [pgs_pkg::GRAD_W-1:0] grad_fast_o
);
  import pgs_pkg::*;

  logic signed [LAP_W-1:0]  lap_q, lap_d, lap_term, v_lap;
  logic signed [GRAD_W-1:0] grad_q, grad_d, grad_term, v_grad;
  logic signed [GRAD_W-1:0] grad_slow_q, grad_mid_q;
  logic signed [LAP_W-1:0]  lap_out_q;
  logic signed [GRAD_W-1:0] grad_slow_out_q, grad_mid_out_q, grad_fast_out_q;
  logic                     valid_q;
  logic [STEP_W-1:0]        step_m1;
  logic [1:0]               axis;
  logic [1:0]               nb;
  logic                     last;

  always_comb begin
    v_lap   = LAP_W'(sample_i);
    v_grad  = GRAD_W'(sample_i);
    step_m1 = tap_i.step - STEP_W'(1);
    axis    = step_m1[3:2];
    nb      = step_m1[1:0];
    last    = tap_i.valid && (tap_i.step == STEP_LAST);
    unique case (nb)
      NB_M2: begin
        lap_term  = -v_lap;
        grad_term = v_grad;
      end
      NB_M1: begin
        lap_term  = v_lap <<< 4;
        grad_term = -(v_grad <<< 3);
      end
      NB_P1: begin
        lap_term  = v_lap <<< 4;
        grad_term = v_grad <<< 3;
      end
      default: begin
        lap_term  = -v_lap;
        grad_term = -v_grad;
      end
    endcase
    if (tap_i.step == STEP_CENTER) begin
      lap_d  = LAP_W'(v_lap * LAP_W'(CENTER_COEF));
      grad_d = '0;
    end else begin
      lap_d  = lap_q + lap_term;
      grad_d = (nb == NB_M2) ? grad_term : grad_q + grad_term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_i.valid) begin
      lap_q  <= lap_d;
      grad_q <= grad_d;
      if (tap_i.step != STEP_CENTER && nb == NB_P2) begin
        if (axis == AXIS_SLOW) begin
          grad_slow_q <= grad_d;
        end
        if (axis == AXIS_MID) begin
          grad_mid_q <= grad_d;
        end
      end
    end
    if (last) begin
      lap_out_q       <= lap_d;
      grad_slow_out_q <= grad_slow_q;
      grad_mid_out_q  <= grad_mid_q;
      grad_fast_out_q <= grad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= last;
    end
  end

  assign result_valid_o  = valid_q;
  assign laplacian_sum_o = lap_out_q;
  assign grad_slow_o     = grad_slow_out_q;
  assign grad_mid_o      = grad_mid_out_q;
  assign grad_fast_o     = grad_fast_out_q;

endmodule

// ----- rtl/periodic_grid_stencil_4th_order_unit.sv -----
// Top level of the periodic grid stencil unit: grid memory, read sequencer, accumulator.
// Depends on pgs_pkg, pgs_grid_mem, pgs_seq and pgs_accum.
//
// The block holds a cube of 2**SIDE_BITS samples per side. A transaction is
// accepted at a rising edge where start is high and busy is low. A write
// transaction (operation_i low) stores value_i at index_i in that cycle,
// leaves busy low and returns nothing, so writes can follow back to back.
// A query transaction reads the center and its twelve neighbors, one per
// cycle from the single memory port, wrapping on each axis separately.
// Busy stays high from the accepting edge of a query until the cycle in which
// the result is shown. The result is shown for exactly one cycle with
// result_valid_o high, once the last sample is folded in, and is taken at
// the edge that ends it; a new transaction may be accepted at that same edge.
// A new query thus waits until the last one is through: its thirteen reads
// through the memory port, the fold of the last sample and the idle cycle in
// which the next start is taken. The receiver cannot stall the result, so no
// result is ever held back or lost.
// Reset clears the sequencer and the result strobe. The grid contents are
// not cleared; every point must be written before a query reads it.
module periodic_grid_stencil_4th_order_unit #(
  parameter int unsigned SIDE_BITS = pgs_pkg::SIDE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [pgs_pkg::INDEX_W-1:0]        index_i,
  input  logic signed [pgs_pkg::VALUE_W-1:0] value_i,
  output logic                               result_valid_o,
  output logic signed [pgs_pkg::LAP_W-1:0]   laplacian_sum_o,
  output logic signed [pgs_pkg::GRAD_W-1:0]  grad_slow_o,
  output logic signed [pgs_pkg::GRAD_W-1:0]  grad_mid_o,
  output logic signed [pgs_pkg::GRAD_W-1:0]  grad_fast_o
);
  import pgs_pkg::*;

  localparam int unsigned CELL_W = 3 * SIDE_BITS;
  localparam int unsigned ADDR_W = (CELL_W < INDEX_W) ? CELL_W : INDEX_W;

  logic              accept;
  logic              mem_we;
  logic              mem_en;
  logic [ADDR_W-1:0] mem_addr;
  logic [VALUE_W-1:0] mem_rdata;
  logic              rd_en;
  logic [CELL_W-1:0] rd_addr;
  pgs_tap_t          tap;

  assign accept   = start && !busy;
  assign mem_we   = accept && (operation_i == OP_WRITE);
  assign mem_en   = mem_we || rd_en;
  assign mem_addr = mem_we ? index_i[ADDR_W-1:0] : rd_addr[ADDR_W-1:0];

  pgs_grid_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (VALUE_W)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (value_i),
    .rdata_o (mem_rdata)
  );

  pgs_seq #(
    .SIDE_BITS (SIDE_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .query_i   (accept && (operation_i == OP_QUERY)),
    .index_i   (index_i),
    .busy_o    (busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .tap_o     (tap)
  );

  pgs_accum u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tap_i           (tap),
    .sample_i        (mem_rdata),
    .result_valid_o  (result_valid_o),
    .laplacian_sum_o (laplacian_sum_o),
    .grad_slow_o     (grad_slow_o),
    .grad_mid_o      (grad_mid_o),
    .grad_fast_o     (grad_fast_o)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for periodic_grid_stencil_4th_order_unit: writes samples, queries stencils whose
// thirteen cells are all written, and checks every result against a built-in predictor.
// Depends on pgs_pkg and the periodic_grid_stencil_4th_order_unit module.
module tb;
  import pgs_pkg::*;

  localparam int SB = SIDE_BITS_DEF;
  localparam int CELLS = 1 << (3 * SB);
  localparam int STENCIL_CELLS = 13;
  localparam int PHASE_ITEMS = 270;
  localparam int MAX_REPORTS = 10;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic signed [VALUE_W-1:0] SAMPLE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] SAMPLE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef logic [SB-1:0] axis_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic signed [VALUE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [LAP_W-1:0]  laplacian;
    logic signed [GRAD_W-1:0] grad_slow;
    logic signed [GRAD_W-1:0] grad_mid;
    logic signed [GRAD_W-1:0] grad_fast;
  } stencil_result_t;

  class stencil_scoreboard;
    sample_t grid_q [CELLS];
    stencil_result_t pending_q [$];
    int unsigned mismatches;

    // Cell 0 is the center; then four taps per axis at -2, -1, +1 and +2, wrapping per axis.
    function index_t stencil_cell(index_t center, int n);
      axis_t c [3];
      int ax;
      int tap;
      c[0] = center[3*SB-1:2*SB];
      c[1] = center[2*SB-1:SB];
      c[2] = center[SB-1:0];
      if (n > 0) begin
        ax = (n - 1) / 4;
        tap = (n - 1) % 4;
        c[ax] = axis_t'(int'(c[ax]) + ((tap < 2) ? tap - 2 : tap - 1));
      end
      return index_t'({c[0], c[1], c[2]});
    endfunction

    function stencil_result_t stencil_sums(index_t center);
      stencil_result_t r;
      longint mid_v;
      longint lap;
      longint grad;
      longint tap [4];
      mid_v = grid_q[stencil_cell(center, 0)];
      lap = 0;
      for (int ax = 0; ax < 3; ax++) begin
        for (int k = 0; k < 4; k++) begin
          tap[k] = grid_q[stencil_cell(center, 1 + 4 * ax + k)];
        end
        lap += -tap[0] + 16 * tap[1] - 30 * mid_v + 16 * tap[2] - tap[3];
        grad = tap[0] - 8 * tap[1] + 8 * tap[2] - tap[3];
        if (ax == 0) begin
          r.grad_slow = GRAD_W'(grad);
        end else if (ax == 1) begin
          r.grad_mid = GRAD_W'(grad);
        end else begin
          r.grad_fast = GRAD_W'(grad);
        end
      end
      r.laplacian = LAP_W'(lap);
      return r;
    endfunction

    function void note_transaction(logic op, index_t idx, sample_t val);
      if (op == OP_WRITE) begin
        grid_q[idx] = val;
      end else begin
        pending_q.push_back(stencil_sums(idx));
      end
    endfunction

    function void report(string msg);
      if (mismatches < MAX_REPORTS) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
    endfunction

    function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        report($sformatf("%s expected %0d, got %0d", name, want, got));
      end
    endfunction

    function void check_result(stencil_result_t got);
      stencil_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with no query pending, laplacian %0d", got.laplacian));
      end else begin
        want = pending_q.pop_front();
        compare_field("laplacian_sum", want.laplacian, got.laplacian);
        compare_field("grad_slow", want.grad_slow, got.grad_slow);
        compare_field("grad_mid", want.grad_mid, got.grad_mid);
        compare_field("grad_fast", want.grad_fast, got.grad_fast);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic operation_i = OP_WRITE;
  index_t index_i = '0;
  sample_t value_i = '0;
  logic busy;
  logic result_valid_o;
  logic signed [LAP_W-1:0] laplacian_sum_o;
  logic signed [GRAD_W-1:0] grad_slow_o;
  logic signed [GRAD_W-1:0] grad_mid_o;
  logic signed [GRAD_W-1:0] grad_fast_o;

  stencil_scoreboard sb = new;
  index_t ready_q [$];
  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned cycle_count;

  periodic_grid_stencil_4th_order_unit #(
    .SIDE_BITS(SB)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .laplacian_sum_o(laplacian_sum_o),
    .grad_slow_o    (grad_slow_o),
    .grad_mid_o     (grad_mid_o),
    .grad_fast_o    (grad_fast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{laplacian_sum_o, grad_slow_o, grad_mid_o, grad_fast_o});
    end
  end

  function automatic sample_t sample_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return SAMPLE_MAX;
    end else if (pick == 1) begin
      return SAMPLE_MIN;
    end else if (pick == 2) begin
      return '0;
    end
    return sample_t'($urandom());
  endfunction

  task automatic send_transaction(input logic op, input index_t idx, input sample_t val);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    index_i <= idx;
    value_i <= val;
    do @(posedge clk_i); while (busy);
    sb.note_transaction(op, idx, val);
    items_sent++;
  endtask

  task automatic query_stencil(input index_t center);
    send_transaction(OP_QUERY, center, sample_t'($urandom()));
  endtask

  task automatic run_directed();
    sample_t val;
    for (int n = 0; n < STENCIL_CELLS; n++) begin
      val = (n > 0 && ((n - 1) % 4 == 1 || (n - 1) % 4 == 2)) ? SAMPLE_MAX : SAMPLE_MIN;
      send_transaction(OP_WRITE, sb.stencil_cell('0, n), val);
    end
    query_stencil('0);
    send_transaction(OP_WRITE, '0, SAMPLE_MAX);
    query_stencil('0);
    send_transaction(OP_WRITE, index_t'(CELLS - 1), '0);
    ready_q.push_back('0);
  endtask

  task automatic run_phase(input int unsigned pct);
    int unsigned target;
    int unsigned stop_at;
    int unsigned pick;
    index_t center;
    idle_pct = pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 7) == 0) begin
          center = $urandom_range(0, 1) ? index_t'(CELLS - 1) : '0;
        end else begin
          center = index_t'($urandom());
        end
        stop_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, STENCIL_CELLS - 1)
                                                : STENCIL_CELLS;
        for (int n = 0; n < stop_at; n++) begin
          send_transaction(OP_WRITE, sb.stencil_cell(center, n), sample_value());
        end
        if (stop_at == STENCIL_CELLS) begin
          query_stencil(center);
          ready_q.push_back(center);
        end
      end else if (pick < 80 && ready_q.size() > 0) begin
        query_stencil(ready_q[$urandom_range(0, ready_q.size() - 1)]);
      end else begin
        send_transaction(OP_WRITE, index_t'($urandom()), sample_value());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 33;
    run_directed();
    run_phase(33);
    run_phase(78);
    run_phase(0);
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
